// File: design/fcarw_pkg.sv
package fcarw_pkg;

    // Default out-of-order window depth in frames
    localparam int DEF_WINDOW_BITS = 32;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    // Width register reset value and legal range
    localparam logic [5:0] WIDTH_RESET = 6'd32;
    localparam logic [5:0] WIDTH_MIN   = 6'd1;
    localparam logic [5:0] WIDTH_MAX   = 6'd32;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SESSION_BITS = 2'd0,
        REG_FRAME_BITS   = 2'd1
    } cfg_reg_t;

    // Item commands
    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_LOAD  = 1'b1
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_RANGE  = 2'd1,
        STATUS_REJECT = 2'd2
    } status_t;

    // Clamp a width register to 1..32
    function automatic logic [5:0] clamp_width(input logic [5:0] w);
        logic [5:0] r;
        if (w < WIDTH_MIN) begin
            r = WIDTH_MIN;
        end
        else if (w > WIDTH_MAX) begin
            r = WIDTH_MAX;
        end
        else begin
            r = w;
        end
        return r;
    endfunction

    // All-ones mask of the clamped width
    function automatic logic [31:0] width_mask(input logic [5:0] w);
        logic [5:0] cw;
        cw = clamp_width(w);
        return 32'hFFFF_FFFF >> (WIDTH_MAX - cw);
    endfunction

    // Increment, wrapping at the given width
    function automatic logic [31:0] bump(input logic [31:0] v, input logic [5:0] w);
        return (v + 32'd1) & width_mask(w);
    endfunction

endpackage

// File: design/frame_counter_anti_replay_window.sv
// Latency: a result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the input side stalls only while a finished
// result is held and out_ready is low.
// The range check, replay check, counter increment and window shift of one word
// are all resolved in a single pass between the input handshake and the result register.
// Reset: min_session = 1, min_frame = 0, window cleared, both widths = 32, no result held.
module frame_counter_anti_replay_window
    import fcarw_pkg::*;
#(
    parameter int WINDOW_BITS = DEF_WINDOW_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cmd,
    input  logic [31:0]            frame_session,
    input  logic [31:0]            frame_count,
    input  logic                   auth_ok,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic                   save_first_valid,
    output logic [31:0]            save_first_session,
    output logic                   save_second_valid,
    output logic [31:0]            save_second_session,
    output logic [31:0]            current_session,
    output logic [31:0]            current_frame,
    output logic                   sessions_exhausted,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [31:0] WIN_DEPTH = 32'(WINDOW_BITS);
    localparam logic [WINDOW_BITS-1:0] WIN_ONES = {WINDOW_BITS{1'b1}};
    localparam logic [WINDOW_BITS-1:0] WIN_ONE  = {{(WINDOW_BITS-1){1'b0}}, 1'b1};

    // Counter state and window
    logic [5:0]             session_bits_reg;
    logic [5:0]             frame_bits_reg;
    logic [31:0]            min_session_reg;
    logic [31:0]            min_session_next;
    logic [31:0]            min_frame_reg;
    logic [31:0]            min_frame_next;
    logic [WINDOW_BITS-1:0] late_window_reg;
    logic [WINDOW_BITS-1:0] late_window_next;

    // Result register
    logic                   out_valid_reg;
    status_t                status_reg;
    status_t                status_next;
    logic                   s1v_reg;
    logic                   s1v_next;
    logic [31:0]            s1_reg;
    logic [31:0]            s1_next;
    logic                   s2v_reg;
    logic                   s2v_next;
    logic [31:0]            s2_reg;
    logic [31:0]            s2_next;

    logic                   in_fire;
    logic [31:0]            sess_lim;
    logic [31:0]            frame_lim;
    logic [31:0]            back_gap;
    logic [31:0]            back_gap_m1;
    logic [31:0]            fwd_gap;
    logic [WINDOW_BITS-1:0] win_probe;
    logic [WINDOW_BITS-1:0] win_shifted;
    logic [WINDOW_BITS-1:0] win_fill;
    logic [31:0]            frame_inc;
    logic [31:0]            sess_inc;
    logic                   reject;
    logic                   late;

    // Handshakes: accept a new word whenever the result slot is free or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Range limits and gap arithmetic
    assign sess_lim    = width_mask(session_bits_reg);
    assign frame_lim   = width_mask(frame_bits_reg);
    assign back_gap    = min_frame_reg - frame_count - 32'd1;
    assign back_gap_m1 = back_gap - 32'd1;
    assign fwd_gap     = frame_count - min_frame_reg;
    assign win_probe   = late_window_reg >> back_gap_m1;
    assign frame_inc   = bump(frame_count, frame_bits_reg);
    assign sess_inc    = bump(frame_session, session_bits_reg);

    // Slide the window forward; a shift by the full depth clears it
    always_comb
    begin
        if ((fwd_gap + 32'd1) >= WIN_DEPTH) begin
            win_shifted = '0;
        end
        else begin
            win_shifted = late_window_reg << (fwd_gap + 32'd1);
        end
        if (fwd_gap >= WIN_DEPTH) begin
            win_fill = WIN_ONES;
        end
        else begin
            win_fill = ~(WIN_ONES << fwd_gap);
        end
    end

    // Check one word and work out the next state and result
    always_comb
    begin
        min_session_next = min_session_reg;
        min_frame_next   = min_frame_reg;
        late_window_next = late_window_reg;
        status_next      = STATUS_OK;
        s1v_next         = 1'b0;
        s1_next          = '0;
        s2v_next         = 1'b0;
        s2_next          = '0;
        reject           = 1'b0;
        late             = 1'b0;

        if (frame_session > sess_lim || frame_count > frame_lim) begin
            status_next = STATUS_RANGE;
        end
        else if (cmd == CMD_LOAD) begin
            min_session_next = frame_session;
            min_frame_next   = frame_count;
            late_window_next = '0;
            s1v_next         = 1'b1;
            s1_next          = frame_session + 32'd1;
        end
        else begin
            // Drop stale sessions; a late frame needs its skipped bit set
            if (frame_session == 32'd0 || frame_session < min_session_reg) begin
                reject = 1'b1;
            end
            else if (frame_session == min_session_reg && frame_count < min_frame_reg) begin
                if (back_gap < 32'd1 || back_gap > WIN_DEPTH || !win_probe[0]) begin
                    reject = 1'b1;
                end
                else begin
                    late = 1'b1;
                end
            end

            if (reject || !auth_ok) begin
                status_next = STATUS_REJECT;
            end
            else begin
                if (frame_session > min_session_reg) begin
                    s1v_next         = 1'b1;
                    s1_next          = sess_inc;
                    late_window_next = '0;
                    min_session_next = frame_session;
                end
                else if (!late) begin
                    late_window_next = win_shifted | win_fill;
                end
                else begin
                    late_window_next = late_window_reg & ~(WIN_ONE << back_gap_m1);
                end

                // Advance the frame counter; on wrap move to the next session
                if (!late) begin
                    min_frame_next = frame_inc;
                    if (frame_inc == 32'd0) begin
                        min_session_next = sess_inc;
                        s2v_next         = 1'b1;
                        s2_next          = (sess_inc == 32'd0) ? 32'd0
                                                               : bump(sess_inc, session_bits_reg);
                        late_window_next = '0;
                    end
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            session_bits_reg <= WIDTH_RESET;
            frame_bits_reg   <= WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SESSION_BITS: session_bits_reg <= cfg_data;
                REG_FRAME_BITS:   frame_bits_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Counter state: commit on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_session_reg <= 32'd1;
            min_frame_reg   <= '0;
            late_window_reg <= '0;
        end
        else if (in_fire) begin
            min_session_reg <= min_session_next;
            min_frame_reg   <= min_frame_next;
            late_window_reg <= late_window_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: hold until the next accepted word
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            status_reg <= status_next;
            s1v_reg    <= s1v_next;
            s1_reg     <= s1_next;
            s2v_reg    <= s2v_next;
            s2_reg     <= s2_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign status              = status_reg;
    assign save_first_valid    = s1v_reg;
    assign save_first_session  = s1_reg;
    assign save_second_valid   = s2v_reg;
    assign save_second_session = s2_reg;
    assign current_session     = min_session_reg;
    assign current_frame       = min_frame_reg;
    assign sessions_exhausted  = (min_session_reg == 32'd0);

`ifndef SYNTHESIS
    // A rejected or out-of-range word leaves the counters and window alone
    a_reject_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && status_next != STATUS_OK
        |=> $stable(min_session_reg) && $stable(min_frame_reg) && $stable(late_window_reg))
        else $error("rejected word changed counter state");

    // A successful load clears the window
    a_load_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && cmd == CMD_LOAD && status_next == STATUS_OK
        |=> late_window_reg == '0)
        else $error("load left window bits set");

    // A second recovery state only follows a frame counter wrap
    a_wrap_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && s2v_reg |-> min_frame_reg == 32'd0 && late_window_reg == '0)
        else $error("second recovery state without frame counter wrap");

    // No input stall while the result slot is empty
    a_free_slot_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result slot");
`endif

endmodule
